// ----- rtl/core/nbm_pkg.sv -----
// Shared types, codes and helpers for the nibble bank mapper.
`default_nettype none
package nbm_pkg;

   typedef enum logic [1:0] {
      OP_WRITE = 2'd0,
      OP_TICK  = 2'd1,
      OP_PRG   = 2'd2,
      OP_CHR   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      CSR_PRG_COUNT   = 2'd0,
      CSR_CHR_COUNT   = 2'd1,
      CSR_INIT_MIRROR = 2'd2
   } csr_index_type;

   // register pages, decoded from A15-A12
   localparam logic [3:0] PAGE_PRG01     = 4'h8;
   localparam logic [3:0] PAGE_PRG2      = 4'h9;
   localparam logic [3:0] PAGE_CHR_FIRST = 4'hA;
   localparam logic [3:0] PAGE_CHR_LAST  = 4'hD;
   localparam logic [3:0] PAGE_LATCH     = 4'hE;
   localparam logic [3:0] PAGE_IRQ       = 4'hF;

   // sub-register codes within the IRQ page, decoded from A1-A0
   localparam logic [1:0] SUB_IRQ_ENABLE = 2'd0;
   localparam logic [1:0] SUB_IRQ_ACK    = 2'd1;
   localparam logic [1:0] SUB_MIRROR     = 2'd3;

   localparam int PRG_SLOTS  = 3;
   localparam int CHR_SLOTS  = 8;
   localparam int BANK_W     = 8;
   localparam int DIV_STEPS  = BANK_W;
   localparam int STEP_W     = $clog2(DIV_STEPS);
   localparam int ROM_W      = 21;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 7;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_DIV  = 3'b010,
      ST_EMIT = 3'b100
   } state_type;

   typedef struct packed {
      logic cap;       // latch accepted item, apply its state update, seed divider
      logic div_step;  // one restoring step of the modulo unit
      logic load_out;  // load the result register
   } cmd_type;

   typedef struct packed {
      logic need_div;  // accepted item needs a bank reduction
   } sts_type;

   function automatic logic [BANK_W-1:0] put_nibble(input logic [BANK_W-1:0] cur,
                                                    input logic hi,
                                                    input logic [3:0] nib);
      logic [BANK_W-1:0] res;
      if (hi) begin
         res = {nib, cur[3:0]};
      end else begin
         res = {cur[7:4], nib};
      end
      return res;
   endfunction

endpackage
`default_nettype wire

// ----- rtl/core/nbm_if.sv -----
// Request and response channel interfaces of the nibble bank mapper.
`default_nettype none
interface nbm_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  opcode;
   logic [15:0] address;
   logic [7:0]  data;

   modport source (output valid, output opcode, output address, output data, input ready);
   modport sink   (input valid, input opcode, input address, input data, output ready);
endinterface

interface nbm_rsp_if;
   logic        valid;
   logic        ready;
   logic [20:0] rom_address;
   logic        irq_line;
   logic [1:0]  mirror_mode;

   modport source (output valid, output rom_address, output irq_line, output mirror_mode,
                   input ready);
   modport sink   (input valid, input rom_address, input irq_line, input mirror_mode,
                   output ready);
endinterface
`default_nettype wire

// ----- rtl/core/nbm_ctrl.sv -----
// Sequencer: accepts a beat, runs the modulo steps if the item needs them, loads the result register.
`default_nettype none
module nbm_ctrl (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  wire logic            rsp_ready,
   input  wire nbm_pkg::sts_type sts,
   output nbm_pkg::cmd_type     cmd
);
   import nbm_pkg::*;

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              out_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.cap  = 1'b1;
               step_in  = '0;
               state_in = sts.need_div ? ST_DIV : ST_EMIT;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            step_in      = step_ff + 1'b1;
            if (step_ff == STEP_W'(DIV_STEPS - 1)) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule
`default_nettype wire

// ----- rtl/core/nbm_dpath.sv -----
// Datapath: bank and IRQ registers, config, shared modulo unit, result register.
`default_nettype none
module nbm_dpath (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire nbm_pkg::cmd_type                cmd,
   output nbm_pkg::sts_type                     sts,
   input  wire logic [1:0]                      req_opcode,
   input  wire logic [15:0]                     req_address,
   input  wire logic [7:0]                      req_data,
   input  wire logic                            csr_we,
   input  wire logic [nbm_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [nbm_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output logic [nbm_pkg::ROM_W-1:0]            rsp_rom_address,
   output logic                                 rsp_irq_line,
   output logic [1:0]                           rsp_mirror_mode
);
   import nbm_pkg::*;

   // configuration
   logic [6:0] prg_cnt_ff;
   logic [4:0] chr_cnt_ff;

   // mapper state
   logic [BANK_W-1:0] prg_bank_ff [PRG_SLOTS];
   logic [BANK_W-1:0] prg_bank_in [PRG_SLOTS];
   logic [BANK_W-1:0] chr_bank_ff [CHR_SLOTS];
   logic [BANK_W-1:0] chr_bank_in [CHR_SLOTS];
   logic [15:0] latch_ff, latch_in;
   logic [15:0] counter_ff, counter_in;
   logic        irq_en_ff, irq_en_in;
   logic        pend_ff, pend_in;
   logic [1:0]  mirror_ff, mirror_in;

   // captured item and modulo unit
   logic [1:0]        op_ff;
   logic [15:0]       addr_ff;
   logic [BANK_W-1:0] rem_ff, rem_in;
   logic [BANK_W-1:0] dvd_ff, dvd_in;
   logic [BANK_W-1:0] den_ff;

   // result register
   logic [ROM_W-1:0] rom_ff, rom_in;
   logic             irq_out_ff;
   logic [1:0]       mir_out_ff;

   logic [BANK_W-1:0] prg_bank_num, chr_bank_num;
   logic [BANK_W-1:0] req_dividend, req_divisor;
   logic [3:0]        wr_page, chr_page_off;
   logic [1:0]        wr_sub, req_slot, cur_slot;
   logic [2:0]        chr_wr_idx;
   logic [BANK_W:0]   shifted, trial;
   logic [BANK_W-1:0] out_bank;

   assign prg_bank_num = {prg_cnt_ff, 1'b0};
   assign chr_bank_num = {chr_cnt_ff, 3'b000};
   assign req_slot     = req_address[14:13];

   // --- item needs a reduction, and the operands that seed the divider
   always_comb begin
      sts.need_div = 1'b0;
      req_dividend = chr_bank_ff[req_address[12:10]];
      req_divisor  = chr_bank_num;
      if (req_opcode == OP_PRG) begin
         req_divisor  = prg_bank_num;
         sts.need_div = req_address[15] && (prg_cnt_ff != '0) && (req_slot != 2'd3);
         case (req_slot)
            2'd0:    req_dividend = prg_bank_ff[0];
            2'd1:    req_dividend = prg_bank_ff[1];
            2'd2:    req_dividend = prg_bank_ff[2];
            default: req_dividend = '0;
         endcase
      end else if (req_opcode == OP_CHR) begin
         sts.need_div = (req_address[15:13] == 3'd0) && (chr_cnt_ff != '0);
      end
   end

   // --- register writes and scanline ticks
   assign wr_page      = req_address[15:12];
   assign wr_sub       = req_address[1:0];
   assign chr_page_off = wr_page - PAGE_CHR_FIRST;
   assign chr_wr_idx   = {chr_page_off[1:0], req_address[1]};

   always_comb begin
      for (int i = 0; i < PRG_SLOTS; i++) begin
         prg_bank_in[i] = prg_bank_ff[i];
      end
      for (int i = 0; i < CHR_SLOTS; i++) begin
         chr_bank_in[i] = chr_bank_ff[i];
      end
      latch_in   = latch_ff;
      counter_in = counter_ff;
      irq_en_in  = irq_en_ff;
      pend_in    = pend_ff;
      mirror_in  = mirror_ff;

      if (cmd.cap && (req_opcode == OP_WRITE)) begin
         if (wr_page == PAGE_PRG01) begin
            for (int i = 0; i < 2; i++) begin
               if (req_address[1] == 1'(i)) begin
                  prg_bank_in[i] = put_nibble(prg_bank_ff[i], req_address[0], req_data[3:0]);
               end
            end
         end else if (wr_page == PAGE_PRG2) begin
            if (!wr_sub[1]) begin
               prg_bank_in[2] = put_nibble(prg_bank_ff[2], req_address[0], req_data[3:0]);
            end
         end else if (wr_page inside {[PAGE_CHR_FIRST:PAGE_CHR_LAST]}) begin
            for (int i = 0; i < CHR_SLOTS; i++) begin
               if (chr_wr_idx == 3'(i)) begin
                  chr_bank_in[i] = put_nibble(chr_bank_ff[i], req_address[0], req_data[3:0]);
               end
            end
         end else if (wr_page == PAGE_LATCH) begin
            for (int j = 0; j < 4; j++) begin
               if (wr_sub == 2'(j)) begin
                  latch_in[j*4 +: 4] = req_data[3:0];
               end
            end
         end else if (wr_page == PAGE_IRQ) begin
            if (wr_sub == SUB_IRQ_ENABLE) begin
               irq_en_in = req_data[0];
            end else if (wr_sub == SUB_IRQ_ACK) begin
               pend_in    = 1'b0;
               counter_in = latch_ff;
            end else if (wr_sub == SUB_MIRROR) begin
               mirror_in = req_data[1:0];
            end
         end
      end else if (cmd.cap && (req_opcode == OP_TICK)) begin
         if (irq_en_ff && (counter_ff != '0)) begin
            counter_in = counter_ff - 16'd1;
            if (counter_ff == 16'd1) begin
               pend_in = 1'b1;
            end
         end
      end

      // writing the initial mirroring also restarts the live mode
      if (csr_we && (csr_index == CSR_INIT_MIRROR)) begin
         mirror_in = {1'b0, csr_wdata[0]};
      end
   end

   // --- restoring modulo, one dividend bit per step
   assign shifted = {rem_ff, dvd_ff[BANK_W-1]};
   assign trial   = shifted - {1'b0, den_ff};

   always_comb begin
      rem_in = rem_ff;
      dvd_in = dvd_ff;
      if (cmd.cap) begin
         rem_in = '0;
         dvd_in = req_dividend;
      end else if (cmd.div_step) begin
         dvd_in = {dvd_ff[BANK_W-2:0], 1'b0};
         rem_in = trial[BANK_W] ? shifted[BANK_W-1:0] : trial[BANK_W-1:0];
      end
   end

   // --- translated address from the captured item
   assign cur_slot = addr_ff[14:13];

   always_comb begin
      rom_in   = '0;
      out_bank = rem_ff;
      if (op_ff == OP_PRG) begin
         if (prg_cnt_ff == '0) begin
            out_bank = '0;
         end else if (cur_slot == 2'd3) begin
            out_bank = prg_bank_num - 8'd1;
         end
         if (addr_ff[15]) begin
            rom_in = {out_bank, addr_ff[12:0]};
         end
      end else if (op_ff == OP_CHR) begin
         if (addr_ff[15:13] == 3'd0) begin
            if (chr_cnt_ff == '0) begin
               rom_in = {5'd0, addr_ff};
            end else begin
               rom_in = {3'd0, rem_ff, addr_ff[9:0]};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prg_cnt_ff  <= 7'd2;
         chr_cnt_ff  <= 5'd1;
         for (int i = 0; i < PRG_SLOTS; i++) begin
            prg_bank_ff[i] <= BANK_W'(i);
         end
         for (int i = 0; i < CHR_SLOTS; i++) begin
            chr_bank_ff[i] <= BANK_W'(i);
         end
         latch_ff   <= '0;
         counter_ff <= '0;
         irq_en_ff  <= 1'b0;
         pend_ff    <= 1'b0;
         mirror_ff  <= 2'd0;
      end else begin
         if (csr_we && (csr_index == CSR_PRG_COUNT)) begin
            prg_cnt_ff <= csr_wdata[6:0];
         end
         if (csr_we && (csr_index == CSR_CHR_COUNT)) begin
            chr_cnt_ff <= csr_wdata[4:0];
         end
         for (int i = 0; i < PRG_SLOTS; i++) begin
            prg_bank_ff[i] <= prg_bank_in[i];
         end
         for (int i = 0; i < CHR_SLOTS; i++) begin
            chr_bank_ff[i] <= chr_bank_in[i];
         end
         latch_ff   <= latch_in;
         counter_ff <= counter_in;
         irq_en_ff  <= irq_en_in;
         pend_ff    <= pend_in;
         mirror_ff  <= mirror_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      if (cmd.cap) begin
         op_ff   <= req_opcode;
         addr_ff <= req_address;
         den_ff  <= req_divisor;
      end
      if (cmd.load_out) begin
         rom_ff     <= rom_in;
         irq_out_ff <= pend_ff;
         mir_out_ff <= mirror_ff;
      end
   end

   assign rsp_rom_address = rom_ff;
   assign rsp_irq_line    = irq_out_ff;
   assign rsp_mirror_mode = mir_out_ff;

endmodule
`default_nettype wire

// ----- rtl/core/nibble_bank_mapper_scanline_irq.sv -----
// Top level of the nibble-loaded bank mapper with scanline IRQ counter.
//
// req_ch carries one beat per item: opcode (write, tick, PRG lookup, CHR
// lookup), a 16-bit address and a data byte. rsp_ch returns exactly one beat
// per item: the translated ROM offset (zero for writes and ticks), the IRQ
// line and the mirroring mode as they stand after the item.
// csr_we/csr_index/csr_wdata load the PRG size, the CHR size and the initial
// mirroring; writes land at the clock edge, no wait, no read-back.
//
// Writes, ticks and lookups that need no bank reduction go from the accepting
// edge straight to the emit state, which loads the result register and raises
// rsp valid; a lookup that reduces its bank modulo the bank count first runs
// the 8-step restoring modulo unit (one dividend bit per cycle). req_ch.ready
// is high only while the sequencer is idle, so one item is taken at a time.
// The result register lets a new beat be accepted while the previous
// result waits; with the receiver stalled, the next item completes its work
// and then holds until the result register frees.
// Reset (synchronous, active high) restores the bank registers to their
// power-on banks, clears the IRQ state and drops rsp_ch.valid.
`default_nettype none
module nibble_bank_mapper_scanline_irq (
   input  wire logic                            clock,
   input  wire logic                            reset,
   nbm_req_if.sink                              req_ch,
   nbm_rsp_if.source                            rsp_ch,
   input  wire logic                            csr_we,
   input  wire logic [nbm_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [nbm_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import nbm_pkg::*;

   cmd_type cmd;
   sts_type sts;

   nbm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   nbm_dpath u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_opcode      (req_ch.opcode),
      .req_address     (req_ch.address),
      .req_data        (req_ch.data),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .rsp_rom_address (rsp_ch.rom_address),
      .rsp_irq_line    (rsp_ch.irq_line),
      .rsp_mirror_mode (rsp_ch.mirror_mode)
   );

   // one item in flight: an accepted beat closes the request side next cycle
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> !req_ch.ready)
      else $error("request accepted while an item is in flight");

   // a stalled result beat stays valid and unchanged
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && !rsp_ch.ready) |=>
         (rsp_ch.valid && $stable(rsp_ch.rom_address) && $stable(rsp_ch.irq_line)
          && $stable(rsp_ch.mirror_mode)))
      else $error("result beat changed while stalled");

   // the sequencer's load command never comes with a capture or a modulo step
   a_load_from_emit: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> !cmd.cap && !cmd.div_step)
      else $error("conflicting sequencer commands");

endmodule
`default_nettype wire

// ----- dv/nbm_mapper_checker.sv -----
// Scoreboard for the nibble bank mapper: predicts every response beat and compares it.
module nbm_mapper_checker
   import nbm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   nbm_req_if                    req_ch,
   nbm_rsp_if                    rsp_ch,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    fail_count,
   output int                    beats_owed
);

   typedef struct packed {
      logic [ROM_W-1:0] rom_address;
      logic             irq_line;
      logic [1:0]       mirror_mode;
   } mapper_result_type;

   // configuration copy
   logic [6:0]        prg_16k_count;
   logic [4:0]        chr_8k_count;

   // mapper state copy
   logic [BANK_W-1:0] prg_bank [PRG_SLOTS];
   logic [BANK_W-1:0] chr_bank [CHR_SLOTS];
   logic [15:0]       reload_latch;
   logic [15:0]       down_counter;
   logic              irq_on;
   logic              irq_flag;
   logic [1:0]        mirroring;

   mapper_result_type owed_results [$];
   int                mismatches;

   initial begin
      fail_count = 0;
      beats_owed = 0;
      mismatches = 0;
   end

   task automatic clear_mapper();
      prg_16k_count = 7'd2;
      chr_8k_count  = 5'd1;
      for (int i = 0; i < PRG_SLOTS; i++) prg_bank[i] = BANK_W'(i);
      for (int i = 0; i < CHR_SLOTS; i++) chr_bank[i] = BANK_W'(i);
      reload_latch = '0;
      down_counter = '0;
      irq_on       = 1'b0;
      irq_flag     = 1'b0;
      mirroring    = 2'd0;
   endtask

   // applies one request beat to the state copy and returns the response it should produce
   function automatic mapper_result_type translate_beat(input op_type op,
                                                        input logic [15:0] addr,
                                                        input logic [7:0] data);
      logic [3:0]        page;
      logic [2:0]        chr_idx;
      int                prg_banks;
      int                chr_banks;
      int                bank;
      mapper_result_type res;
      page = addr[15:12];
      res.rom_address = '0;
      case (op)
         OP_WRITE: begin
            // only A15-A12 and A1-A0 decode; A0 picks the nibble
            if (page == PAGE_PRG01) begin
               prg_bank[addr[1]][addr[0]*4 +: 4] = data[3:0];
            end else if (page == PAGE_PRG2) begin
               if (!addr[1]) prg_bank[2][addr[0]*4 +: 4] = data[3:0];
            end else if (page >= PAGE_CHR_FIRST && page <= PAGE_CHR_LAST) begin
               chr_idx = {2'(page - PAGE_CHR_FIRST), addr[1]};
               chr_bank[chr_idx][addr[0]*4 +: 4] = data[3:0];
            end else if (page == PAGE_LATCH) begin
               reload_latch[addr[1:0]*4 +: 4] = data[3:0];
            end else if (page == PAGE_IRQ) begin
               case (addr[1:0])
                  SUB_IRQ_ENABLE: irq_on = data[0];
                  SUB_IRQ_ACK: begin
                     irq_flag     = 1'b0;
                     down_counter = reload_latch;
                  end
                  SUB_MIRROR: mirroring = data[1:0];
                  default: ;
               endcase
            end
         end
         OP_TICK: begin
            if (irq_on && down_counter != 16'd0) begin
               down_counter = down_counter - 16'd1;
               if (down_counter == 16'd0) irq_flag = 1'b1;
            end
         end
         OP_PRG: begin
            if (addr[15]) begin
               prg_banks = 2 * int'(prg_16k_count);
               if (prg_banks == 0) begin
                  bank = 0;
               end else if (addr[14:13] == 2'd3) begin
                  bank = prg_banks - 1;   // last slot is hardwired to the last bank
               end else begin
                  bank = int'(prg_bank[addr[14:13]]) % prg_banks;
               end
               res.rom_address = ROM_W'((bank << 13) | int'(addr[12:0]));
            end
         end
         OP_CHR: begin
            if (addr < 16'h2000) begin
               chr_banks = 8 * int'(chr_8k_count);
               if (chr_banks == 0) begin
                  res.rom_address = ROM_W'(addr);   // CHR RAM: no translation
               end else begin
                  bank = int'(chr_bank[addr[12:10]]) % chr_banks;
                  res.rom_address = ROM_W'((bank << 10) | int'(addr[9:0]));
               end
            end
         end
         default: ;
      endcase
      res.irq_line    = irq_flag;
      res.mirror_mode = mirroring;
      return res;
   endfunction

   always @(posedge clock) begin
      mapper_result_type want;
      mapper_result_type got;
      if (reset) begin
         clear_mapper();
         owed_results.delete();
         mismatches = 0;
      end else begin
         if (csr_we) begin
            case (csr_index_type'(csr_index))
               CSR_PRG_COUNT:   prg_16k_count = csr_wdata[6:0];
               CSR_CHR_COUNT:   chr_8k_count  = csr_wdata[4:0];
               CSR_INIT_MIRROR: mirroring     = {1'b0, csr_wdata[0]};
               default: ;
            endcase
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.rom_address = rsp_ch.rom_address;
            got.irq_line    = rsp_ch.irq_line;
            got.mirror_mode = rsp_ch.mirror_mode;
            if (owed_results.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: response beat with nothing outstanding: rom=%h irq=%b mirror=%0d",
                           $realtime, got.rom_address, got.irq_line, got.mirror_mode);
            end else begin
               want = owed_results.pop_front();
               if (want !== got) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("%0t: exp rom=%h irq=%b mir=%0d got rom=%h irq=%b mir=%0d",
                              $realtime,
                              want.rom_address, want.irq_line, want.mirror_mode,
                              got.rom_address, got.irq_line, got.mirror_mode);
               end
            end
         end
         if (req_ch.valid && req_ch.ready)
            owed_results.push_back(translate_beat(op_type'(req_ch.opcode), req_ch.address,
                                                  req_ch.data));
      end
      fail_count <= mismatches;
      beats_owed <= owed_results.size();
   end

endmodule

// ----- dv/nibble_bank_mapper_scanline_irq_tb.sv -----
// Top of the nibble bank mapper testbench: clock, reset, stimulus, back-pressure and verdict.
module nibble_bank_mapper_scanline_irq_tb;
   import nbm_pkg::*;

   localparam int IDLE_LIMIT = 4000;

   // response back-pressure styles
   localparam int HOLD_NONE        = 0;
   localparam int HOLD_RANDOM      = 1;
   localparam int HOLD_EVERY_THIRD = 2;
   localparam int HOLD_LONG        = 3;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   int                    fail_count;
   int                    beats_owed;
   int                    burst_left = 0;
   int                    beats_sent = 0;
   int                    idle_cycles = 0;

   nbm_req_if req_ch ();
   nbm_rsp_if rsp_ch ();

   nibble_bank_mapper_scanline_irq u_top (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   nbm_mapper_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .rsp_ch     (rsp_ch),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .beats_owed (beats_owed)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // register address with random don't-care bits A11-A2
   function automatic logic [15:0] reg_addr(input logic [3:0] page, input logic [1:0] sub);
      logic [9:0] mid;
      mid = 10'($urandom);
      return {page, mid, sub};
   endfunction

   task automatic send_item(input op_type op, input logic [15:0] addr, input logic [7:0] data);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 8);
         if (gap != 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 10);
      end
      req_ch.valid   <= 1'b1;
      req_ch.opcode  <= op;
      req_ch.address <= addr;
      req_ch.data    <= data;
      do @(posedge clock); while (!req_ch.ready);
      burst_left--;
      beats_sent++;
   endtask

   // stop offering and wait for every outstanding response beat
   task automatic drain();
      req_ch.valid <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (beats_owed != 0);
   endtask

   task automatic apply_config(input int prg, input int chr, input int mir);
      csr_we    <= 1'b1;
      csr_index <= CSR_PRG_COUNT;
      csr_wdata <= CSR_DATA_W'(prg);
      @(posedge clock);
      csr_index <= CSR_CHR_COUNT;
      csr_wdata <= CSR_DATA_W'(chr);
      @(posedge clock);
      csr_index <= CSR_INIT_MIRROR;
      csr_wdata <= CSR_DATA_W'(mir);
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic run_random(input int n);
      int          stop;
      int          pick;
      int          lv;
      int          slot;
      logic [15:0] a;
      logic [7:0]  d;
      op_type      op;
      stop = beats_sent + n;
      while (beats_sent < stop) begin
         pick = $urandom_range(0, 99);
         if (pick < 10) begin
            // program a short reload, enable, acknowledge, then tick through zero
            lv = $urandom_range(1, 6);
            send_item(OP_WRITE, reg_addr(PAGE_LATCH, 2'd0), {4'($urandom), 4'(lv)});
            send_item(OP_WRITE, reg_addr(PAGE_LATCH, 2'd1), {4'($urandom), 4'h0});
            send_item(OP_WRITE, reg_addr(PAGE_LATCH, 2'd2), {4'($urandom), 4'h0});
            send_item(OP_WRITE, reg_addr(PAGE_LATCH, 2'd3), {4'($urandom), 4'h0});
            send_item(OP_WRITE, reg_addr(PAGE_IRQ, SUB_IRQ_ENABLE), {7'($urandom), 1'b1});
            send_item(OP_WRITE, reg_addr(PAGE_IRQ, SUB_IRQ_ACK), 8'($urandom));
            repeat (lv + $urandom_range(0, 2)) begin
               if ($urandom_range(0, 3) == 0)
                  send_item(OP_CHR, 16'($urandom_range(0, 16'h1FFF)), 8'($urandom));
               send_item(OP_TICK, 16'($urandom), 8'($urandom));
            end
            if ($urandom_range(0, 1))
               send_item(OP_WRITE, reg_addr(PAGE_IRQ, SUB_IRQ_ACK), 8'($urandom));
            if ($urandom_range(0, 4) == 0)
               send_item(OP_WRITE, reg_addr(PAGE_IRQ, SUB_IRQ_ENABLE), {7'($urandom), 1'b0});
         end else if (pick < 25) begin
            // load both nibbles of one bank, then look through it
            if ($urandom_range(0, 1)) begin
               slot = $urandom_range(0, 2);
               a = reg_addr((slot == 2) ? PAGE_PRG2 : PAGE_PRG01, {slot == 1, 1'b0});
               send_item(OP_WRITE, a, 8'($urandom));
               send_item(OP_WRITE, a | 16'h0001, 8'($urandom));
               send_item(OP_PRG, {1'b1, 2'(slot), 13'($urandom)}, 8'($urandom));
            end else begin
               slot = $urandom_range(0, 7);
               a = reg_addr(PAGE_CHR_FIRST + 4'(slot >> 1), {slot[0], 1'b0});
               send_item(OP_WRITE, a, 8'($urandom));
               send_item(OP_WRITE, a | 16'h0001, 8'($urandom));
               send_item(OP_CHR, {3'b000, 3'(slot), 10'($urandom)}, 8'($urandom));
            end
         end else begin
            op = op_type'($urandom_range(0, 3));
            a  = 16'($urandom);
            d  = 8'($urandom);
            case (op)
               OP_WRITE: if ($urandom_range(0, 6) != 0) a[15] = 1'b1;
               OP_PRG:   if ($urandom_range(0, 6) != 0) a[15] = 1'b1;
               OP_CHR:   if ($urandom_range(0, 4) != 0) a[15:13] = 3'b000;
               default: ;
            endcase
            send_item(op, a, d);
         end
      end
   endtask

   task automatic run_phase(input int prg, input int chr, input int mir, input int n);
      drain();
      apply_config(prg, chr, mir);
      run_random(n);
   endtask

   // response back-pressure, cycling through its own stall styles
   initial begin
      int seg;
      int span;
      int mode;
      rsp_ch.ready <= 1'b0;
      do @(posedge clock); while (reset);
      seg = 0;
      forever begin
         mode = (seg % 6 == 2) ? HOLD_LONG : $urandom_range(HOLD_NONE, HOLD_EVERY_THIRD);
         span = (mode == HOLD_LONG) ? 160 : $urandom_range(10, 60);
         for (int c = 0; c < span; c++) begin
            case (mode)
               HOLD_NONE:        rsp_ch.ready <= 1'b1;
               HOLD_RANDOM:      rsp_ch.ready <= ($urandom_range(0, 99) < 60);
               HOLD_EVERY_THIRD: rsp_ch.ready <= (c % 3 == 0);
               default:          rsp_ch.ready <= 1'b0;
            endcase
            @(posedge clock);
         end
         seg++;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin
      req_ch.valid   <= 1'b0;
      req_ch.opcode  <= OP_WRITE;
      req_ch.address <= '0;
      req_ch.data    <= '0;
      csr_we         <= 1'b0;
      csr_index      <= CSR_PRG_COUNT;
      csr_wdata      <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: power-on banks, PRG slots incl. fixed last slot and below $8000
      send_item(OP_PRG, 16'h8000, 8'h00);
      send_item(OP_PRG, 16'hA123, 8'hFF);
      send_item(OP_PRG, 16'hDFFF, 8'h00);
      send_item(OP_PRG, 16'hFFFF, 8'hFF);
      send_item(OP_PRG, 16'h7FFF, 8'h00);
      send_item(OP_CHR, 16'h0000, 8'h00);
      send_item(OP_CHR, 16'h1FFF, 8'hFF);
      send_item(OP_CHR, 16'hFFFF, 8'h00);
      // nibble loads, upper data bits ignored
      send_item(OP_WRITE, 16'h8001, 8'hF5);
      send_item(OP_WRITE, 16'h8000, 8'h0A);
      send_item(OP_PRG, 16'h8000, 8'h00);
      // ignored writes
      send_item(OP_WRITE, 16'h9002, 8'hFF);
      send_item(OP_WRITE, 16'hF002, 8'hFF);
      send_item(OP_WRITE, 16'h1234, 8'hFF);
      // mirrored decode: page B, A1 set, middle bits all ones
      send_item(OP_WRITE, 16'hBFFE, 8'h0C);
      // IRQ: tick while disabled, then count down through zero and past it
      send_item(OP_WRITE, 16'hE000, 8'h12);
      send_item(OP_WRITE, 16'hE001, 8'h30);
      send_item(OP_TICK, 16'h0000, 8'h00);
      send_item(OP_WRITE, 16'hF000, 8'h01);
      send_item(OP_WRITE, 16'hF001, 8'h00);
      send_item(OP_TICK, 16'hFFFF, 8'hFF);
      send_item(OP_TICK, 16'h0000, 8'h00);
      send_item(OP_TICK, 16'h0000, 8'h00);
      send_item(OP_WRITE, 16'hF001, 8'h00);
      send_item(OP_WRITE, 16'hF003, 8'hFF);

      run_phase(1, 0, 1, 118);
      run_phase(127, 31, 0, 118);
      run_phase(0, 31, 1, 118);
      run_phase(5, 3, 0, 118);
      run_phase($urandom_range(1, 127), $urandom_range(0, 31), $urandom_range(0, 1), 118);
      run_phase(2, 1, 0, 118);
      run_phase($urandom_range(1, 127), $urandom_range(1, 31), $urandom_range(0, 1), 117);

      drain();
      repeat (20) @(posedge clock);
      if (fail_count == 0 && beats_owed == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
